// ===== src/tmt_pkg.sv =====
// package for the timestamped message table
// holds field widths, operation and status codes, and controller/datapath link types
// no dependencies
package tmt_pkg;

    localparam int OP_W      = 2;
    localparam int KEY_W     = 32;
    localparam int TIME_W    = 48;
    localparam int PAY_W     = 64;
    localparam int AGE_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;
    localparam int ENTRY_W   = KEY_W + TIME_W + PAY_W;

    localparam logic [AGE_W-1:0]   AGE_RESET = 32'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    // operation codes
    localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
    localparam logic [OP_W-1:0] OP_SWEEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_NEWER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SWEEP     = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } tmt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic nop_op;
        logic scan_last;
        logic out_free;
    } tmt_sts_t;

endpackage

// ===== src/tmt_if.sv =====
// channel interfaces for the timestamped message table
// request carries one operation, response carries one result
// depends on tmt_pkg
interface tmt_req_if
    import tmt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    message_id;
    logic [TIME_W-1:0]   time_ms;
    logic [PAY_W-1:0]    payload_in;

    modport source (output valid, op, message_id, time_ms, payload_in, input ready);
    modport sink (input valid, op, message_id, time_ms, payload_in, output ready);
endinterface

interface tmt_rsp_if
    import tmt_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [TIME_W-1:0]    found_time_ms;
    logic [PAY_W-1:0]     found_payload;
    logic [COUNT_W-1:0]   removed_count;

    modport source (output valid, status, found_time_ms, found_payload, removed_count,
                    input ready);
    modport sink (input valid, status, found_time_ms, found_payload, removed_count,
                  output ready);
endinterface

// ===== src/tmt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module tmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/tmt_ctrl.sv =====
// controller for the timestamped message table
// sequences accept, table scan, drain and commit; depends on tmt_pkg
module tmt_ctrl
    import tmt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  tmt_sts_t sts,
    output tmt_cmd_t cmd
);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !sts.nop_op)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a scan always runs to its end before the drain
    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> ($past(state_reg) == S_SCAN && $past(sts.scan_last)))
        else $error("drain entered before the last entry was read");

    // only one transaction in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");

    // a commit always returns to idle
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == S_IDLE))
        else $error("commit did not return to idle");
endmodule

// ===== src/tmt_dp.sv =====
// datapath for the timestamped message table
// item registers, scan compare, valid bits, entry ram and output register
// depends on tmt_pkg and tmt_ram
module tmt_dp
    import tmt_pkg::*;
#(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tmt_cmd_t             cmd,
    output tmt_sts_t             sts,
    input  logic                 cfg_wr_en,
    input  logic [AGE_W-1:0]     cfg_wr_data,
    input  logic [OP_W-1:0]      in_op,
    input  logic [KEY_W-1:0]     in_message_id,
    input  logic [TIME_W-1:0]    in_time_ms,
    input  logic [PAY_W-1:0]     in_payload_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  out_status,
    output logic [TIME_W-1:0]    out_found_time_ms,
    output logic [PAY_W-1:0]     out_found_payload,
    output logic [COUNT_W-1:0]   out_removed_count
);
    localparam int IDX_W = $clog2(TABLE_CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_CAPACITY - 1);

    logic [AGE_W-1:0]          age_reg;
    logic [OP_W-1:0]           op_reg;
    logic [KEY_W-1:0]          key_reg;
    logic [TIME_W-1:0]         tms_reg;
    logic [PAY_W-1:0]          pay_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      cmp_valid_reg;
    logic [IDX_W-1:0]          cmp_idx_reg;
    logic                      match_found_reg;
    logic [IDX_W-1:0]          match_idx_reg;
    logic [TIME_W-1:0]         match_time_reg;
    logic [PAY_W-1:0]          match_pay_reg;
    logic                      free_found_reg;
    logic [IDX_W-1:0]          free_idx_reg;
    logic [COUNT_W-1:0]        removed_reg;
    logic [TABLE_CAPACITY-1:0] valid_reg;
    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [TIME_W-1:0]         out_time_reg;
    logic [PAY_W-1:0]          out_pay_reg;
    logic [COUNT_W-1:0]        out_removed_reg;

    logic [ENTRY_W-1:0]        rd_data;
    logic [KEY_W-1:0]          rd_key;
    logic [TIME_W-1:0]         rd_time;
    logic [PAY_W-1:0]          rd_pay;
    logic                      ent_valid;
    logic                      key_hit;
    logic                      is_free;
    logic                      expired;
    logic [TIME_W:0]           limit_sum;

    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic                      set_valid;
    logic [STATUS_W-1:0]       res_status;
    logic [TIME_W-1:0]         res_time;
    logic [PAY_W-1:0]          res_pay;
    logic [COUNT_W-1:0]        res_removed;

    // entry storage: key, time, payload
    tmt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_CAPACITY)
    ) u_entry_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({key_reg, tms_reg, pay_reg}),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign rd_key  = rd_data[ENTRY_W-1 -: KEY_W];
    assign rd_time = rd_data[PAY_W +: TIME_W];
    assign rd_pay  = rd_data[PAY_W-1:0];

    // status to the controller
    assign sts.nop_op    = (in_op == OP_NONE);
    assign sts.scan_last = (idx_reg == IDX_LAST);
    assign sts.out_free  = !out_valid_reg || out_ready;

    // compare of the entry read in the previous cycle
    assign ent_valid = valid_reg[cmp_idx_reg];
    assign limit_sum = {1'b0, rd_time} + {{(TIME_W + 1 - AGE_W){1'b0}}, age_reg};
    assign key_hit   = cmp_valid_reg && ent_valid && (rd_key == key_reg);
    assign is_free   = cmp_valid_reg && !ent_valid;
    assign expired   = cmp_valid_reg && ent_valid && (op_reg == OP_SWEEP)
                       && ({1'b0, tms_reg} > limit_sum);

    // commit decision and result
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = match_idx_reg;
        set_valid   = 1'b0;
        res_status  = ST_MISS;
        res_time    = '0;
        res_pay     = '0;
        res_removed = '0;
        case (op_reg)
            OP_UPDATE:
            begin
                if (match_found_reg)
                begin
                    if (match_time_reg < tms_reg)
                    begin
                        wr_en      = cmd.commit;
                        res_status = ST_STORED;
                    end
                    else
                    begin
                        res_status = ST_NOT_NEWER;
                    end
                end
                else if (free_found_reg)
                begin
                    wr_en      = cmd.commit;
                    wr_addr    = free_idx_reg;
                    set_valid  = cmd.commit;
                    res_status = ST_STORED;
                end
                else
                begin
                    res_status = ST_FULL;
                end
            end
            OP_SWEEP:
            begin
                res_status  = ST_SWEEP;
                res_removed = removed_reg;
            end
            OP_LOOKUP:
            begin
                if (match_found_reg)
                begin
                    res_status = ST_HIT;
                    res_time   = match_time_reg;
                    res_pay    = match_pay_reg;
                end
            end
            default:
            begin
                res_status = ST_MISS;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_reg <= AGE_RESET;
        end
        else if (cfg_wr_en)
        begin
            age_reg <= cfg_wr_data;
        end
    end

    // scan control and search flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            removed_reg     <= '0;
        end
        else
        begin
            cmp_valid_reg <= cmd.issue;
            cmp_idx_reg   <= idx_reg;
            if (cmd.start)
            begin
                idx_reg         <= '0;
                match_found_reg <= 1'b0;
                free_found_reg  <= 1'b0;
                removed_reg     <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (key_hit && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                end
                if (is_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
                if (expired && (removed_reg != COUNT_MAX))
                begin
                    removed_reg <= removed_reg + 1'b1;
                end
            end
        end
    end

    // item and captured entry payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= in_op;
            key_reg <= in_message_id;
            tms_reg <= in_time_ms;
            pay_reg <= in_payload_in;
        end
        if (key_hit && !match_found_reg)
        begin
            match_idx_reg  <= cmp_idx_reg;
            match_time_reg <= rd_time;
            match_pay_reg  <= rd_pay;
        end
        if (is_free && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
    end

    // valid bits: cleared by sweep, set by insert
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (expired)
        begin
            valid_reg[cmp_idx_reg] <= 1'b0;
        end
        else if (set_valid)
        begin
            valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status_reg  <= res_status;
            out_time_reg    <= res_time;
            out_pay_reg     <= res_pay;
            out_removed_reg <= res_removed;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_status        = out_status_reg;
    assign out_found_time_ms = out_time_reg;
    assign out_found_payload = out_pay_reg;
    assign out_removed_count = out_removed_reg;

    // the controller commits only into a free output slot
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("result overwrote an untaken transaction");

    // a new result appears only after a commit
    a_rise_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result shown without commit");

    // removed count only on sweep results
    a_removed_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_SWEEP)) |-> (out_removed_reg == '0))
        else $error("removed count on a non-sweep result");

    // found fields only on lookup hits
    a_found_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_HIT))
        |-> (out_time_reg == '0 && out_pay_reg == '0))
        else $error("found fields set on a non-hit result");
endmodule

// ===== src/timestamped_message_table.sv =====
// Timestamped message table, keyed by 32-bit message id.
// Request channel: op (update, age sweep, lookup), message_id, time_ms and
// payload_in. Response channel: one result per update, sweep or lookup with
// status, found_time_ms, found_payload and removed_count. Op code three is
// taken and dropped with no response.
// Each operation walks the whole entry ram, one entry read per cycle, then
// passes through the drain and done states before its result is committed
// to the output register. A new request is taken only once the previous one
// is committed, so no new item is taken while another is still in flight.
// If the receiver stalls, the result waits in the output register; the next
// request may be accepted and scanned, and it waits before commit until the
// output register is free.
// Reset clears all entry valid bits at once and sets age_limit_ms to 1000;
// no clearing pass is needed. The user must write age_limit_ms via cfg_wr_en
// and cfg_wr_data while the block is idle; the block does not enforce this.
// Depends on tmt_pkg, tmt_if, tmt_ram, tmt_ctrl and tmt_dp.
module timestamped_message_table
    import tmt_pkg::*;
#(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [AGE_W-1:0]   cfg_wr_data,
    tmt_req_if.sink            request,
    tmt_rsp_if.source          response
);
    tmt_cmd_t cmd;
    tmt_sts_t sts;

    // sequencer
    tmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table datapath
    tmt_dp #(
        .TABLE_CAPACITY (TABLE_CAPACITY)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_op             (request.op),
        .in_message_id     (request.message_id),
        .in_time_ms        (request.time_ms),
        .in_payload_in     (request.payload_in),
        .out_valid         (response.valid),
        .out_ready         (response.ready),
        .out_status        (response.status),
        .out_found_time_ms (response.found_time_ms),
        .out_found_payload (response.found_payload),
        .out_removed_count (response.removed_count)
    );
endmodule
